/* rtl/core/tbop_pkg.sv */
package tbop_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int MAX_RESULTS = 16;
  localparam int ADDR_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int COUNT_W = $clog2(MAX_RESULTS + 1);

  localparam logic [2:0] CMD_TICK = 3'd0;
  localparam logic [2:0] CMD_INIT = 3'd1;
  localparam logic [2:0] CMD_START = 3'd2;
  localparam logic [2:0] CMD_STOP = 3'd3;
  localparam logic [2:0] CMD_DESTROY = 3'd4;
  localparam logic [2:0] CMD_INFO = 3'd5;

  localparam logic [1:0] KIND_EXPIRY = 2'd0;
  localparam logic [1:0] KIND_INFO = 2'd1;
  localparam logic [1:0] KIND_ACK = 2'd2;

  localparam logic [1:0] ST_CREATED = 2'd0;
  localparam logic [1:0] ST_STARTED = 2'd1;
  localparam logic [1:0] ST_STOPPED = 2'd2;
  localparam logic [1:0] ST_DESTROYED = 2'd3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  timer_index;
    logic [31:0] start_delay;
    logic [31:0] period;
    logic        hard_mode;
  } req_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [3:0]  which_timer;
    logic [31:0] info_delay;
    logic [31:0] info_period;
    logic [1:0]  info_state;
    logic        info_hard;
    logic        last_result;
  } rsp_t;

  typedef struct packed {
    logic [31:0] delay;
    logic [31:0] period;
    logic [31:0] remaining;
    logic [1:0]  status;
    logic        hard;
  } entry_t;

endpackage

/* rtl/core/timer_bank_oneshot_periodic_top.sv */
// Channel  Direction  Payload          Handshake
// req      in         tbop_pkg::req_t  req_valid, req_stall
// rsp      out        tbop_pkg::rsp_t  rsp_valid, rsp_stall
//
// An init, start, stop, destroy or info command is accepted with the entry read, then executed.
// A tick walks one timer entry per cycle, unless a held event waits on a stalled output,
// through the single read port of the timer memory, then a flush state sends the final event.
// Reset clears per-entry valid bits at once, so no clearing pass is needed.
// A stalled result output holds the block in place without losing events.
module timer_bank_oneshot_periodic_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  tbop_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output tbop_pkg::rsp_t rsp
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CEX   = 4'b0010,
    S_TEX   = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  tbop_pkg::entry_t mem [tbop_pkg::NUM_TIMERS];
  tbop_pkg::entry_t rdata;
  logic [tbop_pkg::NUM_TIMERS-1:0] ent_valid;
  logic rd_ok;

  logic mem_we;
  logic mem_re;
  logic [tbop_pkg::ADDR_W-1:0] wa;
  logic [tbop_pkg::ADDR_W-1:0] ra;
  tbop_pkg::entry_t wd;

  tbop_pkg::req_t req_q;
  logic idx_ok;
  logic [tbop_pkg::ADDR_W-1:0] cnt;
  logic [tbop_pkg::COUNT_W-1:0] n_rep;
  logic held_valid;
  tbop_pkg::rsp_t held;

  logic accept;
  logic out_free;
  logic load_out;
  tbop_pkg::rsp_t load_data;
  tbop_pkg::entry_t cur;
  tbop_pkg::entry_t upd;
  logic [31:0] load_val;
  logic [31:0] rem_dec;
  logic started;
  logic expire;
  logic report;
  logic advance;
  tbop_pkg::rsp_t ev;

  assign req_stall = (state != S_IDLE);
  assign accept = req_valid && !req_stall;
  assign out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wa] <= wd;
    end
    if (mem_re) begin
      rdata <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (mem_we) begin
        ent_valid[wa] <= 1'b1;
      end
      if (mem_re) begin
        rd_ok <= ent_valid[ra];
      end
    end
  end

  always_comb begin
    cur = rd_ok ? rdata : '0;
    load_val = (cur.delay != 32'd0) ? cur.delay : cur.period;
    rem_dec = (cur.remaining != 32'd0) ? cur.remaining - 32'd1 : 32'd0;
    started = (cur.status == tbop_pkg::ST_STARTED);
    expire = started && (rem_dec == 32'd0);
    report = expire && (n_rep < tbop_pkg::COUNT_W'(tbop_pkg::MAX_RESULTS));
    advance = !(report && held_valid && !out_free);

    upd = cur;
    if (state == S_TEX) begin
      if (started) begin
        upd.remaining = rem_dec;
        if (expire) begin
          if (cur.period != 32'd0) begin
            upd.remaining = cur.period;
          end else begin
            upd.status = tbop_pkg::ST_STOPPED;
          end
        end
      end
    end else begin
      case (req_q.cmd)
        tbop_pkg::CMD_INIT: begin
          upd.delay = req_q.start_delay;
          upd.period = req_q.period;
          upd.hard = req_q.hard_mode;
          upd.remaining = (req_q.start_delay != 32'd0) ? req_q.start_delay : req_q.period;
          upd.status = tbop_pkg::ST_CREATED;
        end
        tbop_pkg::CMD_START: begin
          if (cur.status inside {tbop_pkg::ST_CREATED, tbop_pkg::ST_STOPPED}) begin
            upd.remaining = load_val;
            upd.status = tbop_pkg::ST_STARTED;
          end
        end
        tbop_pkg::CMD_STOP: begin
          if (started) begin
            upd.status = tbop_pkg::ST_STOPPED;
          end
        end
        tbop_pkg::CMD_DESTROY: begin
          upd.status = tbop_pkg::ST_DESTROYED;
        end
        default: begin
        end
      endcase
    end

    ev.result_kind = tbop_pkg::KIND_EXPIRY;
    ev.which_timer = 4'(cnt);
    ev.info_delay = upd.delay;
    ev.info_period = upd.period;
    ev.info_state = upd.status;
    ev.info_hard = upd.hard;
    ev.last_result = 1'b0;
  end

  always_comb begin
    state_next = state;
    mem_we = 1'b0;
    mem_re = 1'b0;
    wa = cnt;
    ra = '0;
    wd = upd;
    load_out = 1'b0;
    load_data = held;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.cmd == tbop_pkg::CMD_TICK) begin
            mem_re = 1'b1;
            state_next = S_TEX;
          end else if (req.cmd inside {[tbop_pkg::CMD_INIT : tbop_pkg::CMD_INFO]}) begin
            mem_re = 1'b1;
            ra = tbop_pkg::ADDR_W'(req.timer_index);
            state_next = S_CEX;
          end
        end
      end
      S_CEX: begin
        wa = tbop_pkg::ADDR_W'(req_q.timer_index);
        if (out_free) begin
          mem_we = idx_ok && (req_q.cmd != tbop_pkg::CMD_INFO);
          load_out = 1'b1;
          load_data.result_kind = (req_q.cmd == tbop_pkg::CMD_INFO) ?
                                  tbop_pkg::KIND_INFO : tbop_pkg::KIND_ACK;
          load_data.which_timer = req_q.timer_index;
          load_data.info_delay = idx_ok ? upd.delay : 32'd0;
          load_data.info_period = idx_ok ? upd.period : 32'd0;
          load_data.info_state = idx_ok ? upd.status : tbop_pkg::ST_DESTROYED;
          load_data.info_hard = idx_ok && upd.hard;
          load_data.last_result = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_TEX: begin
        if (advance) begin
          mem_we = 1'b1;
          load_out = report && held_valid;
          if (32'(cnt) == tbop_pkg::NUM_TIMERS - 1) begin
            state_next = S_FLUSH;
          end else begin
            mem_re = 1'b1;
            ra = cnt + tbop_pkg::ADDR_W'(1);
          end
        end
      end
      S_FLUSH: begin
        if (!held_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          load_out = 1'b1;
          load_data.last_result = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp_valid <= 1'b0;
      held_valid <= 1'b0;
      cnt <= '0;
      n_rep <= '0;
    end else begin
      state <= state_next;
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (accept) begin
        cnt <= '0;
        n_rep <= '0;
      end else if (state == S_TEX && advance) begin
        cnt <= cnt + tbop_pkg::ADDR_W'(1);
        if (report) begin
          held_valid <= 1'b1;
          n_rep <= n_rep + tbop_pkg::COUNT_W'(1);
        end
      end else if (state == S_FLUSH) begin
        if (out_free) begin
          held_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp <= load_data;
    end
    if (accept) begin
      req_q <= req;
      idx_ok <= (32'(req.timer_index) < tbop_pkg::NUM_TIMERS);
    end
    if (state == S_TEX && advance && report) begin
      held <= ev;
    end
  end

`ifndef SYNTHESIS
  a_held_in_tick: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> (state == S_TEX || state == S_FLUSH))
    else $error("Held expiry event outside of a tick.");

  a_no_same_entry: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (wa != ra))
    else $error("Write and read of the same entry in one cycle.");

  a_tick_walk: assert property (@(posedge clk) disable iff (rst)
    (accept && req.cmd == tbop_pkg::CMD_TICK) |=> (state == S_TEX && cnt == '0))
    else $error("Tick did not start its walk at the first timer.");

  a_cmd_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_CEX && out_free) |=> (rsp_valid && rsp.last_result))
    else $error("Command result missing or not marked last.");
`endif

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import tbop_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  logic [31:0] model_delay [NUM_TIMERS];
  logic [31:0] model_period [NUM_TIMERS];
  logic [31:0] model_remaining [NUM_TIMERS];
  logic [1:0]  model_status [NUM_TIMERS];
  logic        model_hard [NUM_TIMERS];
  rsp_t        expected_rsp [$];

  int error_count = 0;
  int sender_max_gap = 8;
  int rsp_max_stall = 8;

  timer_bank_oneshot_periodic_top dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always #6 clk = ~clk;

  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  function automatic rsp_t timer_report(logic [1:0] kind, int idx, logic last);
    rsp_t r;
    r.result_kind = kind;
    r.which_timer = 4'(idx);
    if (idx < NUM_TIMERS) begin
      r.info_delay = model_delay[idx];
      r.info_period = model_period[idx];
      r.info_state = model_status[idx];
      r.info_hard = model_hard[idx];
    end else begin
      r.info_delay = '0;
      r.info_period = '0;
      r.info_state = ST_DESTROYED;
      r.info_hard = 1'b0;
    end
    r.last_result = last;
    return r;
  endfunction

  function automatic void clear_timer_model();
    for (int i = 0; i < NUM_TIMERS; i++) begin
      model_delay[i] = '0;
      model_period[i] = '0;
      model_remaining[i] = '0;
      model_status[i] = ST_CREATED;
      model_hard[i] = 1'b0;
    end
  endfunction

  function automatic void predict_timer_results(req_t r);
    int idx;
    int fired;
    idx = r.timer_index;
    if (r.cmd == CMD_TICK) begin
      fired = 0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (model_status[i] == ST_STARTED) begin
          if (model_remaining[i] != 0) model_remaining[i] = model_remaining[i] - 1;
          if (model_remaining[i] == 0) begin
            if (model_period[i] != 0) model_remaining[i] = model_period[i];
            else model_status[i] = ST_STOPPED;
            if (fired < MAX_RESULTS) begin
              expected_rsp.push_back(timer_report(KIND_EXPIRY, i, 1'b0));
              fired++;
            end
          end
        end
      end
      if (fired > 0) expected_rsp[expected_rsp.size() - 1].last_result = 1'b1;
    end else if (r.cmd <= CMD_INFO) begin
      if (idx < NUM_TIMERS) begin
        case (r.cmd)
          CMD_INIT: begin
            model_delay[idx] = r.start_delay;
            model_period[idx] = r.period;
            model_hard[idx] = r.hard_mode;
            model_remaining[idx] = (r.start_delay != 0) ? r.start_delay : r.period;
            model_status[idx] = ST_CREATED;
          end
          CMD_START: begin
            if (model_status[idx] == ST_CREATED || model_status[idx] == ST_STOPPED) begin
              model_remaining[idx] = (model_delay[idx] != 0) ? model_delay[idx]
                                                             : model_period[idx];
              model_status[idx] = ST_STARTED;
            end
          end
          CMD_STOP: begin
            if (model_status[idx] == ST_STARTED) model_status[idx] = ST_STOPPED;
          end
          CMD_DESTROY: begin
            model_status[idx] = ST_DESTROYED;
          end
          default: begin
          end
        endcase
      end
      expected_rsp.push_back(timer_report((r.cmd == CMD_INFO) ? KIND_INFO : KIND_ACK,
                                          idx, 1'b1));
    end
  endfunction

  // Called at a rising edge; returns at the edge where the transaction is accepted.
  task automatic send_command(logic [2:0] cmd, logic [3:0] idx, logic [31:0] dly,
                              logic [31:0] per, logic hard);
    req_t r;
    int gap;
    r.cmd = cmd;
    r.timer_index = idx;
    r.start_delay = dly;
    r.period = per;
    r.hard_mode = hard;
    gap = $urandom_range(0, sender_max_gap);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    predict_timer_results(r);
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
  endtask

  function automatic logic [31:0] random_count();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) return '0;
    else if (pick < 75) return 32'($urandom_range(1, 5));
    else if (pick < 90) return 32'($urandom_range(6, 40));
    else return $urandom;
  endfunction

  task automatic test_idle_bank();
    send_command(CMD_INFO, 4'd0, '0, '0, 1'b0);
    send_command(CMD_INFO, 4'd15, '1, '1, 1'b1);
    send_command(CMD_TICK, 4'd0, '0, '0, 1'b0);
    send_command(3'd6, 4'd3, 32'd7, 32'd7, 1'b1);
    send_command(3'd7, 4'd15, '1, '1, 1'b1);
    send_command(CMD_STOP, 4'd4, '0, '0, 1'b0);
  endtask

  task automatic test_timer_lifecycle();
    send_command(CMD_INIT, 4'd2, 32'd2, 32'd3, 1'b1);
    send_command(CMD_START, 4'd2, '0, '0, 1'b0);
    send_command(CMD_START, 4'd2, '0, '0, 1'b0);
    send_command(CMD_TICK, 4'd0, '0, '0, 1'b0);
    send_command(CMD_TICK, 4'd0, '0, '0, 1'b0);
    send_command(CMD_STOP, 4'd2, '0, '0, 1'b0);
    send_command(CMD_STOP, 4'd2, '0, '0, 1'b0);
    send_command(CMD_START, 4'd2, '0, '0, 1'b0);
    send_command(CMD_DESTROY, 4'd2, '0, '0, 1'b0);
    send_command(CMD_START, 4'd2, '0, '0, 1'b0);
    send_command(CMD_TICK, 4'd0, '0, '0, 1'b0);
    send_command(CMD_INIT, 4'd2, 32'd0, 32'd1, 1'b0);
    send_command(CMD_START, 4'd2, '0, '0, 1'b0);
    send_command(CMD_INIT, 4'd2, 32'd4, 32'd0, 1'b1);
    send_command(CMD_INFO, 4'd2, '0, '0, 1'b0);
  endtask

  task automatic test_field_extremes();
    send_command(CMD_INIT, 4'd15, '1, '1, 1'b1);
    send_command(CMD_START, 4'd15, '0, '0, 1'b0);
    send_command(CMD_START, 4'd0, '0, '0, 1'b0);
    send_command(CMD_INIT, 4'd1, 32'd1, 32'd0, 1'b0);
    send_command(CMD_START, 4'd1, '0, '0, 1'b0);
    send_command(CMD_TICK, 4'd9, '1, '1, 1'b1);
    send_command(CMD_INFO, 4'd15, '0, '0, 1'b0);
    send_command(CMD_INIT, 4'd15, '0, '0, 1'b0);
  endtask

  task automatic test_full_bank_expiry();
    for (int i = 0; i < NUM_TIMERS; i++)
      send_command(CMD_INIT, 4'(i), 32'd1, 32'(i % 2), 1'($urandom_range(0, 1)));
    for (int i = 0; i < NUM_TIMERS; i++)
      send_command(CMD_START, 4'(i), '0, '0, 1'b0);
    send_command(CMD_TICK, 4'd0, '0, '0, 1'b0);
    send_command(CMD_TICK, 4'd0, '0, '0, 1'b0);
    for (int i = 0; i < NUM_TIMERS; i += 2)
      send_command(CMD_START, 4'(i), '0, '0, 1'b0);
    send_command(CMD_TICK, 4'd0, '0, '0, 1'b0);
  endtask

  task automatic test_random_commands(int count);
    int sent;
    int pick;
    logic [2:0] cmd;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) cmd = CMD_TICK;
      else if (pick < 55) cmd = CMD_INIT;
      else if (pick < 72) cmd = CMD_START;
      else if (pick < 80) cmd = CMD_STOP;
      else if (pick < 85) cmd = CMD_DESTROY;
      else if (pick < 97) cmd = CMD_INFO;
      else cmd = 3'($urandom_range(6, 7));
      send_command(cmd, 4'($urandom_range(0, 15)), random_count(), random_count(),
                   1'($urandom_range(0, 1)));
      if (cmd <= CMD_INFO) sent++;
    end
  endtask

  task automatic test_drain_pause();
    req_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
  endtask

  initial begin
    int hold;
    @(posedge clk);
    forever begin
      hold = $urandom_range(0, rsp_max_stall);
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!rsp_valid);
    end
  end

  always @(posedge clk) begin : result_checker
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        $error("unexpected result transaction: %h", rsp);
        error_count++;
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.result_kind !== want.result_kind) begin
          $error("result_kind: expected %0d, actual %0d", want.result_kind, rsp.result_kind);
          error_count++;
        end
        if (rsp.which_timer !== want.which_timer) begin
          $error("which_timer: expected %0d, actual %0d", want.which_timer, rsp.which_timer);
          error_count++;
        end
        if (rsp.info_delay !== want.info_delay) begin
          $error("info_delay: expected %h, actual %h", want.info_delay, rsp.info_delay);
          error_count++;
        end
        if (rsp.info_period !== want.info_period) begin
          $error("info_period: expected %h, actual %h", want.info_period, rsp.info_period);
          error_count++;
        end
        if (rsp.info_state !== want.info_state) begin
          $error("info_state: expected %0d, actual %0d", want.info_state, rsp.info_state);
          error_count++;
        end
        if (rsp.info_hard !== want.info_hard) begin
          $error("info_hard: expected %0d, actual %0d", want.info_hard, rsp.info_hard);
          error_count++;
        end
        if (rsp.last_result !== want.last_result) begin
          $error("last_result: expected %0d, actual %0d", want.last_result, rsp.last_result);
          error_count++;
        end
      end
    end
  end

  initial begin
    clear_timer_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_idle_bank();
    test_timer_lifecycle();
    test_field_extremes();
    test_full_bank_expiry();
    test_random_commands(60);
    test_drain_pause();
    sender_max_gap = 0;
    rsp_max_stall = 0;
    test_random_commands(40);
    sender_max_gap = 0;
    rsp_max_stall = 8;
    test_random_commands(30);
    sender_max_gap = 8;
    rsp_max_stall = 0;
    test_random_commands(25);
    sender_max_gap = 8;
    rsp_max_stall = 8;
    test_full_bank_expiry();
    test_random_commands(30);

    req_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (4 * (NUM_TIMERS + 2)) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
